### rtl/ffrs_pkg.sv
// Package with the shared types and codes of the free frame run search block.
package ffrs_pkg;

    // Function codes of an input item
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_CONTIG  = 2'd1;
    localparam logic [1:0] FUNC_SCATTER = 2'd2;

    // Fit strategy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_FIT_STRATEGY = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  frame_index;
        logic        frame_free;
        logic [10:0] need;
        logic [6:0]  list_cap;
    } ffrs_cmd_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  result_index;
        logic        last;
    } ffrs_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ffrs_state_t;

    // Control from the sequencer to the run tracker
    typedef struct packed {
        logic load;
        logic scatter;
        logic bit_vld;
        logic bit_end;
        logic finish;
    } ffrs_scan_ctl_t;

endpackage

### rtl/ffrs_bit_ram.sv
// Single-bit-wide frame map memory with one write port and one registered read port.
module ffrs_bit_ram
    import ffrs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ffrs_scan.sv
// Run tracker and free list collector fed one map bit per cycle.
module ffrs_scan
    import ffrs_pkg::*;
#(
    parameter int IW       = 10,
    parameter int MAX_LIST = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ffrs_scan_ctl_t ctl,
    input  logic [10:0]    need,
    input  logic [6:0]     list_cap,
    input  logic [1:0]     fit_strategy,
    input  logic [IW-1:0]  bit_idx,
    input  logic           bit_data,
    output logic           res_vld,
    output ffrs_res_t      res
);

    localparam int CW = (IW + 1 > 11) ? IW + 1 : 11;
    localparam int XW = (IW > 10) ? IW : 10;
    localparam logic [10:0] MAX_LIST_W = 11'(MAX_LIST);

    logic          scatter_reg,    scatter_next;
    logic [10:0]   need_reg,       need_next;
    logic [6:0]    limit_reg,      limit_next;
    logic [IW-1:0] run_start_reg,  run_start_next;
    logic [IW:0]   run_len_reg,    run_len_next;
    logic          have_reg,       have_next;
    logic [IW-1:0] pick_start_reg, pick_start_next;
    logic [IW:0]   best_len_reg,   best_len_next;
    logic [6:0]    cnt_reg,        cnt_next;
    logic          pend_vld_reg,   pend_vld_next;
    logic [IW-1:0] pend_idx_reg,   pend_idx_next;
    logic          res_vld_reg,    res_vld_next;
    ffrs_res_t     res_reg,        res_next;

    logic [10:0]   lim_a;
    logic [IW:0]   len_inc;
    logic          close;
    logic [IW:0]   close_len;
    logic [IW-1:0] close_start;
    logic          fits;
    logic          take;
    logic [XW-1:0] pend_x;
    logic [XW-1:0] best_x;

    assign pend_x = XW'(pend_idx_reg);
    assign best_x = XW'(pick_start_reg);

    assign len_inc     = run_len_reg + 1'b1;
    assign close       = !bit_data || ctl.bit_end;
    assign close_len   = bit_data ? len_inc : run_len_reg;
    assign close_start = (bit_data && run_len_reg == '0) ? bit_idx : run_start_reg;
    assign fits        = (need_reg != 11'd0) && (CW'(close_len) >= CW'(need_reg));

    always_comb
    begin
        unique case (fit_strategy)
            FIT_FIRST: take = !have_reg;
            FIT_BEST:  take = !have_reg || (close_len < best_len_reg);
            FIT_WORST: take = !have_reg || (close_len > best_len_reg);
            default:   take = 1'b0;
        endcase
    end

    always_comb
    begin
        lim_a = ({4'd0, list_cap} < need) ? {4'd0, list_cap} : need;
        if (MAX_LIST_W < lim_a)
        begin
            lim_a = MAX_LIST_W;
        end

        scatter_next    = scatter_reg;
        need_next       = need_reg;
        limit_next      = limit_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        have_next       = have_reg;
        pick_start_next = pick_start_reg;
        best_len_next   = best_len_reg;
        cnt_next        = cnt_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        res_vld_next    = 1'b0;
        res_next        = res_reg;

        priority if (ctl.load)
        begin
            scatter_next  = ctl.scatter;
            need_next     = need;
            limit_next    = lim_a[6:0];
            run_len_next  = '0;
            have_next     = 1'b0;
            cnt_next      = '0;
            pend_vld_next = 1'b0;
        end
        else if (ctl.bit_vld && scatter_reg)
        begin
            // Hold one free index back so the final one can carry last
            if (bit_data && cnt_reg < limit_reg)
            begin
                if (pend_vld_reg)
                begin
                    res_vld_next = 1'b1;
                    res_next     = '{found: 1'b1, result_index: pend_x[9:0], last: 1'b0};
                end
                pend_vld_next = 1'b1;
                pend_idx_next = bit_idx;
                cnt_next      = cnt_reg + 7'd1;
            end
        end
        else if (ctl.bit_vld)
        begin
            if (bit_data)
            begin
                run_len_next   = len_inc;
                run_start_next = close_start;
            end
            if (close)
            begin
                run_len_next = '0;
                if (fits && take)
                begin
                    have_next       = 1'b1;
                    pick_start_next = close_start;
                    best_len_next   = close_len;
                end
            end
        end
        else if (ctl.finish)
        begin
            res_vld_next = 1'b1;
            if (scatter_reg)
            begin
                res_next = pend_vld_reg
                    ? ffrs_res_t'{found: 1'b1, result_index: pend_x[9:0], last: 1'b1}
                    : ffrs_res_t'{found: 1'b0, result_index: 10'd0, last: 1'b1};
            end
            else
            begin
                res_next = '{found: have_reg,
                             result_index: have_reg ? best_x[9:0] : 10'd0,
                             last: 1'b1};
            end
        end
        else
        begin
            // Hold everything while no query is under way
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scatter_reg    <= 1'b0;
            need_reg       <= '0;
            limit_reg      <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            have_reg       <= 1'b0;
            pick_start_reg <= '0;
            best_len_reg   <= '0;
            cnt_reg        <= '0;
            pend_vld_reg   <= 1'b0;
            pend_idx_reg   <= '0;
            res_vld_reg    <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            scatter_reg    <= scatter_next;
            need_reg       <= need_next;
            limit_reg      <= limit_next;
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            have_reg       <= have_next;
            pick_start_reg <= pick_start_next;
            best_len_reg   <= best_len_next;
            cnt_reg        <= cnt_next;
            pend_vld_reg   <= pend_vld_next;
            pend_idx_reg   <= pend_idx_next;
            res_vld_reg    <= res_vld_next;
            res_reg        <= res_next;
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

    a_cnt_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= limit_reg)
        else $error("free list count passed its limit");

    a_mid_result_is_scatter: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_reg.last) |-> (scatter_reg && res_reg.found))
        else $error("non-final beat outside a scattered query");

endmodule

### rtl/free_frame_run_search.sv
// Top level of the free frame run search: sequencer, register port and frame map.
//
//  channel   | handshake              | payload           | notes
//  ----------+------------------------+-------------------+-------------------------------
//  command   | start / busy           | cmd (ffrs_cmd_t)  | taken when start && !busy
//  result    | result_valid strobe    | result            | one cycle, no back-pressure
//  config    | psel/penable/pwrite    | paddr, pwdata     | pready tied high, prdata reads
//
//  A write beat leaves busy low. A query holds busy through the scan, drain
//  and done states: the map memory gives one frame bit per cycle on its
//  single read port, and every query walks the whole map. The last result beat
//  shows in the first cycle with busy low.
//  After reset a clearing pass writes every frame as used, one per cycle, with
//  busy high throughout; configuration writes are taken meanwhile.
//  Result beats cannot be stalled; every beat is shown exactly once.
module free_frame_run_search
    import ffrs_pkg::*;
#(
    parameter int NUM_FRAMES = 1024,
    parameter int MAX_LIST   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ffrs_cmd_t   cmd,
    output logic        result_valid,
    output ffrs_res_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_FRAMES - 1);

    ffrs_state_t    state_reg, state_next;
    logic [IW-1:0]  addr_reg,  addr_next;
    logic [1:0]     fit_strategy_reg;

    // Pipeline stage aligned with the registered memory read data
    logic           proc_vld_reg;
    logic           proc_end_reg;
    logic [IW-1:0]  proc_idx_reg;

    logic           accept;
    logic           in_range;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic           mem_wdata;
    logic           mem_re;
    logic           mem_rdata;
    ffrs_scan_ctl_t scan_ctl;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(cmd.frame_index) < 32'(NUM_FRAMES));

    // Register port: a single strategy register, decoded on the word address bit
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_strategy_reg <= FIT_FIRST;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_FIT_STRATEGY)
        begin
            fit_strategy_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FIT_STRATEGY)
        begin
            prdata = {30'd0, fit_strategy_reg};
        end
    end

    // Sequencer: clear the map, take beats, walk the map for a query
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = 1'b0;
        mem_re     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.func == FUNC_WRITE)
                    begin
                        // Drop writes past the last frame
                        mem_we    = in_range;
                        mem_waddr = IW'(cmd.frame_index);
                        mem_wdata = cmd.frame_free;
                    end
                    else if (cmd.func == FUNC_CONTIG || cmd.func == FUNC_SCATTER)
                    begin
                        addr_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_re    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            proc_vld_reg <= 1'b0;
            proc_end_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            proc_vld_reg <= (state_reg == ST_SCAN);
            proc_end_reg <= (state_reg == ST_SCAN) && (addr_reg == LAST_ADDR);
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= addr_reg;
    end

    // Writes happen only while clearing or idle and reads only while scanning, so the
    // two ports never touch the same entry in the same window.
    ffrs_bit_ram #(
        .DEPTH (NUM_FRAMES),
        .AW    (IW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        scan_ctl.load    = accept && (cmd.func == FUNC_CONTIG || cmd.func == FUNC_SCATTER);
        scan_ctl.scatter = (cmd.func == FUNC_SCATTER);
        scan_ctl.bit_vld = proc_vld_reg;
        scan_ctl.bit_end = proc_end_reg;
        scan_ctl.finish  = (state_reg == ST_DONE);
    end

    ffrs_scan #(
        .IW       (IW),
        .MAX_LIST (MAX_LIST)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .need         (cmd.need),
        .list_cap     (cmd.list_cap),
        .fit_strategy (fit_strategy_reg),
        .bit_idx      (proc_idx_reg),
        .bit_data     (mem_rdata),
        .res_vld      (result_valid),
        .res          (result)
    );

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_CLEAR))
        else $error("map written outside idle or clearing");

    a_done_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (result_valid && result.last))
        else $error("query finished without a final beat");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !result_valid)
        else $error("result beat during the clearing pass");

endmodule
